/* hdl/rip_pkg.sv */
// rip_pkg: shared constants, register codes and types for rgb_invert_posterize
// no dependencies; used by rip_pipe_ctrl, rip_chan and rgb_invert_posterize
package rip_pkg;

  // channel arithmetic width and port field width
  localparam int CHAN_W  = 16;
  localparam int FIELD_W = 16;

  // configuration register widths
  localparam int MAXV_W  = 16;
  localparam int LEVEL_W = 9;
  localparam int CFG_W   = 16;
  localparam int INDEX_W = 2;

  // posterize step count (levels minus one) fits in this many bits
  localparam int STEP_W  = 8;

  // numerator 2*c*steps + mx and product v*mx
  localparam int NUM_W   = CHAN_W + STEP_W + 2;
  localparam int PROD_W  = CHAN_W + STEP_W;

  // level count limits
  localparam logic [LEVEL_W-1:0] LEVEL_MIN = LEVEL_W'(2);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(256);

  // pipeline stage map
  localparam int ST_IN   = 0;                  // clamp and invert
  localparam int ST_NUM  = 1;                  // rounding numerator
  localparam int ST_DIV1 = 2;                  // level quotient, one bit per stage
  localparam int ST_MUL  = ST_DIV1 + STEP_W;   // level times max value
  localparam int ST_DIV2 = ST_MUL + 1;         // output quotient, one bit per stage
  localparam int NUM_STG = ST_DIV2 + CHAN_W;

  // register indexes
  localparam logic [INDEX_W-1:0] REG_MAX_VALUE   = INDEX_W'(0);
  localparam logic [INDEX_W-1:0] REG_LEVEL_COUNT = INDEX_W'(1);
  localparam logic [INDEX_W-1:0] REG_OP_MODE     = INDEX_W'(2);

  // operation codes
  localparam logic MODE_INVERT    = 1'b0;
  localparam logic MODE_POSTERIZE = 1'b1;

  // settings seen by every channel datapath
  typedef struct packed {
    logic [CHAN_W-1:0] mx;
    logic [STEP_W-1:0] steps;
    logic              mode;
  } cfg_t;

endpackage

/* hdl/rip_pipe_ctrl.sv */
// rip_pipe_ctrl: valid bits and per-stage load enables of the pixel pipeline
// depends on rip_pkg
module rip_pipe_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rip_pkg::NUM_STG-1:0] en
);

  logic [rip_pkg::NUM_STG-1:0] vld;
  logic [rip_pkg::NUM_STG:0]   rdy;
  logic [rip_pkg::NUM_STG-1:0] feed;

  // a stage can take an item when empty or when its item moves on
  assign rdy[rip_pkg::NUM_STG] = !out_stall;

  for (genvar s = 0; s < rip_pkg::NUM_STG; s++) begin : g_stage
    assign rdy[s] = !vld[s] || rdy[s+1];

    if (s == 0) begin : g_first
      assign feed[s] = in_valid;
    end else begin : g_rest
      assign feed[s] = vld[s-1];
    end

    assign en[s] = rdy[s] && feed[s];

    // valid bit travels with the data
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld[s] <= feed[s];
      end
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld[rip_pkg::NUM_STG-1];

endmodule

/* hdl/rip_chan.sv */
// rip_chan: datapath of one color channel, clamp, invert and posterize
// two restoring dividers, one quotient bit per stage; depends on rip_pkg
module rip_chan (
  input  logic                        clk,
  input  logic [rip_pkg::NUM_STG-1:0] en,
  input  rip_pkg::cfg_t               cfg,
  input  logic [rip_pkg::FIELD_W-1:0] sample,
  output logic [rip_pkg::FIELD_W-1:0] result
);

  localparam int LAST = rip_pkg::NUM_STG - 1;

  logic [rip_pkg::CHAN_W-1:0] inv_q [rip_pkg::NUM_STG];
  logic [rip_pkg::CHAN_W-1:0] clamp_q;
  logic [rip_pkg::NUM_W-1:0]  num_q;
  logic [rip_pkg::NUM_W-1:0]  rem1 [rip_pkg::STEP_W];
  logic [rip_pkg::STEP_W-1:0] quo1 [rip_pkg::STEP_W];
  logic [rip_pkg::PROD_W-1:0] prod_q;
  logic [rip_pkg::PROD_W-1:0] rem2 [rip_pkg::CHAN_W];
  logic [rip_pkg::CHAN_W-1:0] quo2 [rip_pkg::CHAN_W];

  logic [rip_pkg::CHAN_W-1:0] c_in;
  logic [rip_pkg::CHAN_W-1:0] c_clamp;

  // clamp to max value, invert
  assign c_in    = sample[rip_pkg::CHAN_W-1:0];
  assign c_clamp = (c_in > cfg.mx) ? cfg.mx : c_in;

  always_ff @(posedge clk) begin
    if (en[rip_pkg::ST_IN]) begin
      clamp_q                <= c_clamp;
      inv_q[rip_pkg::ST_IN]  <= cfg.mx - c_clamp;
    end
  end

  // inverted value rides along to the end
  for (genvar s = 1; s < rip_pkg::NUM_STG; s++) begin : g_inv
    always_ff @(posedge clk) begin
      if (en[s]) begin
        inv_q[s] <= inv_q[s-1];
      end
    end
  end

  // rounding numerator 2*c*steps + mx
  always_ff @(posedge clk) begin
    if (en[rip_pkg::ST_NUM]) begin
      num_q <= ((rip_pkg::NUM_W'(clamp_q) * rip_pkg::NUM_W'(cfg.steps)) << 1)
               + rip_pkg::NUM_W'(cfg.mx);
    end
  end

  // level = numerator / (2*mx), msb first
  for (genvar j = 0; j < rip_pkg::STEP_W; j++) begin : g_div1
    localparam int K = rip_pkg::STEP_W - 1 - j;
    logic [rip_pkg::NUM_W-1:0]  rp;
    logic [rip_pkg::STEP_W-1:0] qp;
    logic [rip_pkg::NUM_W-1:0]  dsh;

    if (j == 0) begin : g_first
      assign rp = num_q;
      assign qp = '0;
    end else begin : g_rest
      assign rp = rem1[j-1];
      assign qp = quo1[j-1];
    end

    assign dsh = rip_pkg::NUM_W'({cfg.mx, 1'b0}) << K;

    always_ff @(posedge clk) begin
      if (en[rip_pkg::ST_DIV1 + j]) begin
        if (rp >= dsh) begin
          rem1[j] <= rp - dsh;
          quo1[j] <= qp | (rip_pkg::STEP_W'(1) << K);
        end else begin
          rem1[j] <= rp;
          quo1[j] <= qp;
        end
      end
    end
  end

  // level times max value
  always_ff @(posedge clk) begin
    if (en[rip_pkg::ST_MUL]) begin
      prod_q <= rip_pkg::PROD_W'(quo1[rip_pkg::STEP_W-1]) * rip_pkg::PROD_W'(cfg.mx);
    end
  end

  // output = product / steps, msb first
  for (genvar j = 0; j < rip_pkg::CHAN_W; j++) begin : g_div2
    localparam int K = rip_pkg::CHAN_W - 1 - j;
    logic [rip_pkg::PROD_W-1:0] rp;
    logic [rip_pkg::CHAN_W-1:0] qp;
    logic [rip_pkg::PROD_W-1:0] dsh;

    if (j == 0) begin : g_first
      assign rp = prod_q;
      assign qp = '0;
    end else begin : g_rest
      assign rp = rem2[j-1];
      assign qp = quo2[j-1];
    end

    assign dsh = rip_pkg::PROD_W'(cfg.steps) << K;

    always_ff @(posedge clk) begin
      if (en[rip_pkg::ST_DIV2 + j]) begin
        if (rp >= dsh) begin
          rem2[j] <= rp - dsh;
          quo2[j] <= qp | (rip_pkg::CHAN_W'(1) << K);
        end else begin
          rem2[j] <= rp;
          quo2[j] <= qp;
        end
      end
    end
  end

  // select by mode
  assign result = (cfg.mode == rip_pkg::MODE_POSTERIZE)
                ? rip_pkg::FIELD_W'(quo2[rip_pkg::CHAN_W-1])
                : rip_pkg::FIELD_W'(inv_q[LAST]);

endmodule

/* hdl/rgb_invert_posterize.sv */
// rgb_invert_posterize: top level, configuration registers and three channels
// depends on rip_pkg, rip_pipe_ctrl and rip_chan
//
// Per-pixel point operation. One RGB pixel enters on the input channel
// (in_valid / in_stall with red_in, green_in, blue_in) and one processed
// pixel leaves on the output channel (out_valid / out_stall with red_out,
// green_out, blue_out). op_mode selects invert (max_value - c) or posterize
// (quantize to level_count levels with rounding, then map back). Samples
// above max_value are clamped first.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
// (0 max_value, 1 level_count, 2 op_mode); write only while the pipeline
// holds no item.
// Both modes take the same path: clamp, numerator, an 8-stage level divider,
// a multiply, then a 16-stage output divider, one quotient bit per stage.
// Throughput is one pixel per cycle while out_stall is low.
// Reset empties the pipeline and loads max_value 255, level_count 4 and
// invert mode. A stalled output holds its pixel; empty stages keep filling
// behind it, and in_stall rises only when every stage is occupied.
module rgb_invert_posterize (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [rip_pkg::INDEX_W-1:0] cfg_index,
  input  logic [rip_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rip_pkg::FIELD_W-1:0] red_in,
  input  logic [rip_pkg::FIELD_W-1:0] green_in,
  input  logic [rip_pkg::FIELD_W-1:0] blue_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rip_pkg::FIELD_W-1:0] red_out,
  output logic [rip_pkg::FIELD_W-1:0] green_out,
  output logic [rip_pkg::FIELD_W-1:0] blue_out
);

  logic [rip_pkg::MAXV_W-1:0]  max_value;
  logic [rip_pkg::LEVEL_W-1:0] level_count;
  logic                        op_mode;
  logic [rip_pkg::NUM_STG-1:0] en;
  logic [rip_pkg::STEP_W-1:0]  steps;
  rip_pkg::cfg_t               cfg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_value   <= rip_pkg::MAXV_W'(255);
      level_count <= rip_pkg::LEVEL_W'(4);
      op_mode     <= rip_pkg::MODE_INVERT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rip_pkg::REG_MAX_VALUE:   max_value   <= cfg_data[rip_pkg::MAXV_W-1:0];
        rip_pkg::REG_LEVEL_COUNT: level_count <= cfg_data[rip_pkg::LEVEL_W-1:0];
        rip_pkg::REG_OP_MODE:     op_mode     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // level count limited to its range, minus one
  always_comb begin
    if (level_count < rip_pkg::LEVEL_MIN) begin
      steps = rip_pkg::STEP_W'(1);
    end else if (level_count > rip_pkg::LEVEL_MAX) begin
      steps = rip_pkg::STEP_W'(rip_pkg::LEVEL_MAX - rip_pkg::LEVEL_W'(1));
    end else begin
      steps = rip_pkg::STEP_W'(level_count - rip_pkg::LEVEL_W'(1));
    end
  end

  assign cfg.mx    = max_value[rip_pkg::CHAN_W-1:0];
  assign cfg.steps = steps;
  assign cfg.mode  = op_mode;

  // pipeline control
  rip_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .en        (en)
  );

  // channel datapaths
  rip_chan u_red (
    .clk    (clk),
    .en     (en),
    .cfg    (cfg),
    .sample (red_in),
    .result (red_out)
  );

  rip_chan u_green (
    .clk    (clk),
    .en     (en),
    .cfg    (cfg),
    .sample (green_in),
    .result (green_out)
  );

  rip_chan u_blue (
    .clk    (clk),
    .en     (en),
    .cfg    (cfg),
    .sample (blue_in),
    .result (blue_out)
  );

  // input backs up only behind a held output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output not blocked");

  // pipeline empty after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (!out_valid && !in_stall))
    else $error("pipeline not empty after reset");

  // divider never sees a zero step count
  a_steps_nonzero: assert property (@(posedge clk) disable iff (rst)
    steps != '0)
    else $error("posterize step count is zero");

endmodule

/* verif/rgb_invert_posterize_test.sv */
// rgb_invert_posterize_test: self-checking testbench for the rgb invert/posterize block
// depends on rip_pkg and rgb_invert_posterize; drives pixels, settings and stalls,
// predicts every output pixel and compares it field by field
module rgb_invert_posterize_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1850;
  localparam int HOLD_CYCLES = 150;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [rip_pkg::INDEX_W-1:0] REG_SPARE = rip_pkg::INDEX_W'(3);

  // expected pixel store and point-operation predictor
  class pixel_ledger;
    typedef struct {
      logic [rip_pkg::FIELD_W-1:0] red;
      logic [rip_pkg::FIELD_W-1:0] green;
      logic [rip_pkg::FIELD_W-1:0] blue;
    } pixel_t;

    logic [rip_pkg::MAXV_W-1:0]  max_value_q;
    logic [rip_pkg::LEVEL_W-1:0] level_q;
    logic                        mode_q;
    pixel_t                      expected_q[$];
    int                          errors;
    int                          checked;

    function new();
      max_value_q = rip_pkg::MAXV_W'(255);
      level_q     = rip_pkg::LEVEL_W'(4);
      mode_q      = rip_pkg::MODE_INVERT;
      errors      = 0;
      checked     = 0;
    endfunction

    // mirror of the register file
    function void write_reg(logic [rip_pkg::INDEX_W-1:0] index,
                            logic [rip_pkg::CFG_W-1:0] data);
      case (index)
        rip_pkg::REG_MAX_VALUE:   max_value_q = data[rip_pkg::MAXV_W-1:0];
        rip_pkg::REG_LEVEL_COUNT: level_q = data[rip_pkg::LEVEL_W-1:0];
        rip_pkg::REG_OP_MODE:     mode_q = data[0];
        default: ;
      endcase
    endfunction

    // clamp, then invert or quantize and map back
    function logic [rip_pkg::FIELD_W-1:0] map_channel(logic [rip_pkg::FIELD_W-1:0] sample);
      longint unsigned mx, lv, steps, c, lvl;
      mx = max_value_q;
      lv = level_q;
      if (lv < rip_pkg::LEVEL_MIN) lv = rip_pkg::LEVEL_MIN;
      if (lv > rip_pkg::LEVEL_MAX) lv = rip_pkg::LEVEL_MAX;
      steps = lv - 1;
      c = sample;
      if (c > mx) c = mx;
      if (mode_q == rip_pkg::MODE_INVERT) return rip_pkg::FIELD_W'(mx - c);
      if (mx == 0) return '0;
      // round half up with exact integers
      lvl = (2 * c * steps + mx) / (2 * mx);
      return rip_pkg::FIELD_W'((lvl * mx) / steps);
    endfunction

    function void note_input(logic [rip_pkg::FIELD_W-1:0] r, logic [rip_pkg::FIELD_W-1:0] g,
                             logic [rip_pkg::FIELD_W-1:0] b);
      pixel_t px;
      px.red   = map_channel(r);
      px.green = map_channel(g);
      px.blue  = map_channel(b);
      expected_q.push_back(px);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void compare_field(string name, logic [rip_pkg::FIELD_W-1:0] want,
                                logic [rip_pkg::FIELD_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [rip_pkg::FIELD_W-1:0] r, logic [rip_pkg::FIELD_W-1:0] g,
                               logic [rip_pkg::FIELD_W-1:0] b);
      pixel_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t ns: pixel with none expected, expected none, actual %h %h %h",
                 $time, r, g, b);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      compare_field("red_out", want.red, r);
      compare_field("green_out", want.green, g);
      compare_field("blue_out", want.blue, b);
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [rip_pkg::INDEX_W-1:0]   cfg_index = '0;
  logic [rip_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [rip_pkg::FIELD_W-1:0]   red_in = '0;
  logic [rip_pkg::FIELD_W-1:0]   green_in = '0;
  logic [rip_pkg::FIELD_W-1:0]   blue_in = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [rip_pkg::FIELD_W-1:0]   red_out;
  logic [rip_pkg::FIELD_W-1:0]   green_out;
  logic [rip_pkg::FIELD_W-1:0]   blue_out;

  pixel_ledger ledger = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycles = 0;
  int sent = 0;
  int settings = 0;

  rgb_invert_posterize u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stalls plus long holds on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // handshake monitor, output side first
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) ledger.check_result(red_out, green_out, blue_out);
      if (in_valid && !in_stall) ledger.note_input(red_in, green_in, blue_in);
    end
  end

  // offer one item, with random idle cycles ahead of it
  task automatic send_pixel(logic [rip_pkg::FIELD_W-1:0] r, logic [rip_pkg::FIELD_W-1:0] g,
                            logic [rip_pkg::FIELD_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    red_in   <= r;
    green_in <= g;
    blue_in  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // stop sending until every expected pixel is out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  // one register write; caller lowers the enable
  task automatic write_reg(logic [rip_pkg::INDEX_W-1:0] index,
                           logic [rip_pkg::CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    ledger.write_reg(index, data);
  endtask

  // new setting on an idle pipeline; junk in the unused upper bits
  task automatic apply_setting(logic [rip_pkg::MAXV_W-1:0] mx, logic [rip_pkg::LEVEL_W-1:0] lv,
                               logic mode, bit spare);
    wait_drained();
    write_reg(rip_pkg::REG_MAX_VALUE, mx);
    write_reg(rip_pkg::REG_LEVEL_COUNT, {7'($urandom), lv});
    write_reg(rip_pkg::REG_OP_MODE, {15'($urandom), mode});
    if (spare) write_reg(REG_SPARE, rip_pkg::CFG_W'($urandom));
    cfg_write <= 1'b0;
    settings++;
  endtask

  // extremes, clamp edges and alternating bit patterns
  task automatic directed_burst(logic [rip_pkg::MAXV_W-1:0] mx);
    send_pixel('0, '1, mx);
    send_pixel(mx + 1'b1, mx - 1'b1, mx >> 1);
    send_pixel(16'h5555, 16'haaaa, 16'h0001);
  endtask

  // samples weighted toward the clamp boundary
  function automatic logic [rip_pkg::FIELD_W-1:0] rand_sample(logic [rip_pkg::MAXV_W-1:0] mx);
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return mx;
      3: return mx + 1'b1;
      4: return mx - 1'b1;
      5, 6: return rip_pkg::FIELD_W'($urandom_range(mx));
      default: return rip_pkg::FIELD_W'($urandom);
    endcase
  endfunction

  function automatic logic [rip_pkg::MAXV_W-1:0] rand_max();
    case ($urandom_range(9))
      0: return '0;
      1: return rip_pkg::MAXV_W'(1);
      2: return rip_pkg::MAXV_W'(255);
      3: return '1;
      4, 5: return rip_pkg::MAXV_W'($urandom_range(16, 2));
      default: return rip_pkg::MAXV_W'($urandom_range(65535, 1));
    endcase
  endfunction

  function automatic logic [rip_pkg::LEVEL_W-1:0] rand_level();
    case ($urandom_range(9))
      0: return rip_pkg::LEVEL_W'($urandom_range(1));
      1: return rip_pkg::LEVEL_W'($urandom_range(511, 257));
      2: return rip_pkg::LEVEL_MIN;
      3: return rip_pkg::LEVEL_MAX;
      default: return rip_pkg::LEVEL_W'($urandom_range(256, 2));
    endcase
  endfunction

  // stimulus
  initial begin
    int phase;
    int count;
    logic [rip_pkg::MAXV_W-1:0] mx;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed settings, reset values first
    directed_burst(rip_pkg::MAXV_W'(255));
    apply_setting(rip_pkg::MAXV_W'(255), rip_pkg::LEVEL_W'(4), rip_pkg::MODE_POSTERIZE, 1'b0);
    directed_burst(rip_pkg::MAXV_W'(255));
    // exact half rounds up
    apply_setting(rip_pkg::MAXV_W'(2), rip_pkg::LEVEL_MIN, rip_pkg::MODE_POSTERIZE, 1'b0);
    directed_burst(rip_pkg::MAXV_W'(2));
    // zero max value in both modes
    apply_setting('0, rip_pkg::LEVEL_W'(4), rip_pkg::MODE_POSTERIZE, 1'b0);
    directed_burst('0);
    apply_setting('0, rip_pkg::LEVEL_W'(4), rip_pkg::MODE_INVERT, 1'b0);
    directed_burst('0);
    apply_setting('1, rip_pkg::LEVEL_MAX, rip_pkg::MODE_POSTERIZE, 1'b0);
    directed_burst('1);
    // level count below two and above the top
    apply_setting(rip_pkg::MAXV_W'(1000), rip_pkg::LEVEL_W'(0), rip_pkg::MODE_POSTERIZE, 1'b0);
    directed_burst(rip_pkg::MAXV_W'(1000));
    apply_setting('1, rip_pkg::LEVEL_W'(511), rip_pkg::MODE_POSTERIZE, 1'b1);
    directed_burst('1);

    // random settings and pixels
    phase = 0;
    while (sent < ITEM_TARGET) begin
      phase++;
      mx = rand_max();
      apply_setting(mx, rand_level(), logic'($urandom_range(1)), $urandom_range(7) == 0);
      if (phase % 6 == 3) begin
        hold_asked <= hold_asked + 1;
        count = 120;
      end else begin
        count = $urandom_range(70, 15);
      end
      for (int i = 0; i < count; i++) begin
        // idle mix by progress through the run
        if (sent < ITEM_TARGET / 3) begin
          send_idle_pct = 23;
          recv_idle_pct <= 45;
        end else if (sent < 2 * ITEM_TARGET / 3) begin
          send_idle_pct = 45;
          recv_idle_pct <= 23;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
        if (phase % 7 == 5 && i == count / 2) wait_drained();
        send_pixel(rand_sample(mx), rand_sample(mx), rand_sample(mx));
      end
    end

    // drain and settle
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d pixels checked over %0d register settings, invert and posterize",
             ledger.checked, settings);
    $display("traffic mixed sender and receiver idles, long output holds and full drains");
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/rip_pkg.sv
hdl/rip_pipe_ctrl.sv
hdl/rip_chan.sv
hdl/rgb_invert_posterize.sv
verif/rgb_invert_posterize_test.sv
